// ----- sv/ssbr_pkg.sv -----
`timescale 1ns / 1ps
// Package for the seven-segment blink and refresh block.
// Holds the sizes, operation codes and controller state type. No dependencies.
package ssbr_pkg;

  localparam int DIGITS             = 8;
  localparam int GROUP_BLINK_DIGITS = 2;
  localparam int DOT_BIT            = 7;
  localparam int GROUP_FIRST        = DIGITS - GROUP_BLINK_DIGITS;
  localparam int DIGIT_W            = 3;
  localparam int GROUP_W            = 1;
  localparam logic [7:0] PERIOD_RST = 8'd31;

  typedef enum logic [3:0] {
    OP_TICK        = 4'd0,
    OP_DIGIT_SEGS  = 4'd1,
    OP_GROUP_BLINK = 4'd2,
    OP_HOLD_MASK   = 4'd3,
    OP_DOTS        = 4'd4,
    OP_DOT_BLINK   = 4'd5,
    OP_DIGIT_BLINK = 4'd6,
    OP_UPDATE_NOW  = 4'd7,
    OP_FLASH_NOW   = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_CALC = 2'd2
  } state_t;

endpackage

// ----- sv/ssbr_in_if.sv -----
`timescale 1ns / 1ps
// Input channel: command items (operation, index, value) with valid/ready.
// No dependencies.
interface ssbr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [2:0] index;
  logic [7:0] value;

  modport source (output valid, output operation, output index, output value, input ready);
  modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

// ----- sv/ssbr_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: one segment byte per digit with valid/ready.
// No dependencies.
interface ssbr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit;
  logic [7:0] segments;
  logic       display_on;
  logic       last;

  modport source (output valid, output digit, output segments, output display_on,
                  output last, input ready);
  modport sink   (input valid, input digit, input segments, input display_on,
                  input last, output ready);
endinterface

// ----- sv/seven_segment_blink_refresh.sv -----
`timescale 1ns / 1ps
// Top level of the seven-segment blink and refresh controller.
// Uses ssbr_pkg, ssbr_in_if and ssbr_out_if.
//
// Write commands and requests are taken while idle and give no result. A tick
// either counts the countdown down or starts a refresh run that emits one
// segment byte per digit, digit 0 first, last set on digit 7. Each digit is
// first read from memory, then computed, written back to the output buffer
// and sent out once the output register is free, which an output stall can
// delay; no input is taken during the run. Per-digit segments, hold
// masks and the output buffer share one 8-entry memory with byte lanes; each
// lane has per-entry valid bits so that reset clears it at once.
module seven_segment_blink_refresh (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  ssbr_in_if.sink    in_chan,
  ssbr_out_if.source out_chan
);

  localparam logic [7:0] DOT_MASK = 8'(1 << ssbr_pkg::DOT_BIT);

  ssbr_pkg::state_t state_r, state_nxt;
  logic [ssbr_pkg::DIGIT_W-1:0] pos_r, pos_nxt;

  logic [7:0] flash_period_r, flash_period_nxt;
  logic [7:0] countdown_r, countdown_nxt;
  logic [7:0] dot_r, dot_nxt;
  logic [7:0] dot_blink_r, dot_blink_nxt;
  logic [7:0] digit_blink_r, digit_blink_nxt;
  logic [7:0] group_r [ssbr_pkg::GROUP_BLINK_DIGITS];
  logic [7:0] group_nxt [ssbr_pkg::GROUP_BLINK_DIGITS];
  logic       shown_r, shown_nxt;
  logic       update_r, update_nxt;
  logic       flash_r, flash_nxt;
  logic       flash_blank_r, flash_blank_nxt;

  logic [ssbr_pkg::DIGITS-1:0] seg_vld_r, seg_vld_nxt;
  logic [ssbr_pkg::DIGITS-1:0] hold_vld_r, hold_vld_nxt;
  logic [ssbr_pkg::DIGITS-1:0] obuf_vld_r, obuf_vld_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_digit_r, out_digit_nxt;
  logic [7:0] out_seg_r, out_seg_nxt;
  logic       out_on_r, out_on_nxt;
  logic       out_last_r, out_last_nxt;

  // memory word: [23:16] segments, [15:8] hold mask, [7:0] output buffer
  logic [23:0] mem [ssbr_pkg::DIGITS];
  logic [23:0] rd_r;
  logic        wr_seg, wr_hold, wr_obuf;
  logic [ssbr_pkg::DIGIT_W-1:0] wr_addr;
  logic [7:0]  wr_byte;

  logic        in_xfer, out_xfer, out_free;
  ssbr_pkg::op_t op;
  logic        do_refresh;
  logic [7:0]  enable, dots, data, gmask;
  logic        shown_sel;

  assign in_chan.ready       = (state_r == ssbr_pkg::ST_IDLE);
  assign in_xfer             = in_chan.valid && in_chan.ready;
  assign out_xfer            = out_valid_r && out_chan.ready;
  assign out_free            = !out_valid_r || out_chan.ready;
  assign op                  = ssbr_pkg::op_t'(in_chan.operation);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.digit      = out_digit_r;
  assign out_chan.segments   = out_seg_r;
  assign out_chan.display_on = out_on_r;
  assign out_chan.last       = out_last_r;

  always_ff @(posedge clk) begin
    if (wr_seg)  mem[wr_addr][23:16] <= wr_byte;
    if (wr_hold) mem[wr_addr][15:8]  <= wr_byte;
    if (wr_obuf) mem[wr_addr][7:0]   <= wr_byte;
    if (state_r == ssbr_pkg::ST_READ) begin
      rd_r <= {mem[pos_r][23:16] & {8{seg_vld_r[pos_r]}},
               mem[pos_r][15:8]  & {8{hold_vld_r[pos_r]}},
               mem[pos_r][7:0]   & {8{obuf_vld_r[pos_r]}}};
    end
  end

  always_comb begin
    enable = shown_r ? 8'hff : ~digit_blink_r;
    dots   = shown_r ? (dot_r | dot_blink_r) : (dot_r & ~dot_blink_r);
    gmask  = 8'h00;
    for (int g = 0; g < ssbr_pkg::GROUP_BLINK_DIGITS; g++) begin
      if (32'(pos_r) == ssbr_pkg::GROUP_FIRST + g) gmask = group_r[g];
    end
    data = 8'h00;
    if (enable[pos_r]) begin
      data = rd_r[23:16] & ~DOT_MASK;
      data = shown_r ? (data | gmask) : (data & ~gmask);
    end
    if (dots[pos_r]) data = data | DOT_MASK;
    data = (data & ~rd_r[15:8]) | (rd_r[7:0] & rd_r[15:8]);
  end

  always_comb begin
    state_nxt        = state_r;
    pos_nxt          = pos_r;
    flash_period_nxt = cfg_we ? cfg_wdata : flash_period_r;
    countdown_nxt    = countdown_r;
    dot_nxt          = dot_r;
    dot_blink_nxt    = dot_blink_r;
    digit_blink_nxt  = digit_blink_r;
    group_nxt        = group_r;
    shown_nxt        = shown_r;
    update_nxt       = update_r;
    flash_nxt        = flash_r;
    flash_blank_nxt  = flash_blank_r;
    seg_vld_nxt      = seg_vld_r;
    hold_vld_nxt     = hold_vld_r;
    obuf_vld_nxt     = obuf_vld_r;
    out_valid_nxt    = out_xfer ? 1'b0 : out_valid_r;
    out_digit_nxt    = out_digit_r;
    out_seg_nxt      = out_seg_r;
    out_on_nxt       = out_on_r;
    out_last_nxt     = out_last_r;
    wr_seg           = 1'b0;
    wr_hold          = 1'b0;
    wr_obuf          = 1'b0;
    wr_addr          = in_chan.index;
    wr_byte          = in_chan.value;
    do_refresh       = flash_r || update_r || (countdown_r == 8'd0);
    shown_sel        = flash_r ? !flash_blank_r : !shown_r;

    case (state_r)
      ssbr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (op)
            ssbr_pkg::OP_TICK: begin
              if (do_refresh) begin
                shown_nxt       = shown_sel;
                update_nxt      = 1'b0;
                flash_nxt       = 1'b0;
                flash_blank_nxt = 1'b0;
                countdown_nxt   = flash_period_r;
                pos_nxt         = '0;
                state_nxt       = ssbr_pkg::ST_READ;
              end else begin
                countdown_nxt = countdown_r - 8'd1;
              end
            end
            ssbr_pkg::OP_DIGIT_SEGS: begin
              if (32'(in_chan.index) < ssbr_pkg::DIGITS) begin
                wr_seg                     = 1'b1;
                seg_vld_nxt[in_chan.index] = 1'b1;
              end
            end
            ssbr_pkg::OP_GROUP_BLINK: begin
              if (32'(in_chan.index) < ssbr_pkg::GROUP_BLINK_DIGITS) begin
                group_nxt[in_chan.index[ssbr_pkg::GROUP_W-1:0]] = in_chan.value;
              end
            end
            ssbr_pkg::OP_HOLD_MASK: begin
              if (32'(in_chan.index) < ssbr_pkg::DIGITS) begin
                wr_hold                     = 1'b1;
                hold_vld_nxt[in_chan.index] = 1'b1;
              end
            end
            ssbr_pkg::OP_DOTS:        dot_nxt         = in_chan.value;
            ssbr_pkg::OP_DOT_BLINK:   dot_blink_nxt   = in_chan.value;
            ssbr_pkg::OP_DIGIT_BLINK: digit_blink_nxt = in_chan.value;
            ssbr_pkg::OP_UPDATE_NOW:  update_nxt      = 1'b1;
            ssbr_pkg::OP_FLASH_NOW: begin
              flash_nxt       = 1'b1;
              flash_blank_nxt = in_chan.value[0];
            end
            default: ;
          endcase
        end
      end
      ssbr_pkg::ST_READ: begin
        state_nxt = ssbr_pkg::ST_CALC;
      end
      ssbr_pkg::ST_CALC: begin
        if (out_free) begin
          wr_obuf              = 1'b1;
          wr_addr              = pos_r;
          wr_byte              = data;
          obuf_vld_nxt[pos_r]  = 1'b1;
          out_valid_nxt        = 1'b1;
          out_digit_nxt        = pos_r;
          out_seg_nxt          = data;
          out_on_nxt           = shown_r;
          out_last_nxt         = (32'(pos_r) == ssbr_pkg::DIGITS - 1);
          if (32'(pos_r) == ssbr_pkg::DIGITS - 1) begin
            state_nxt = ssbr_pkg::ST_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ssbr_pkg::ST_READ;
          end
        end
      end
      default: state_nxt = ssbr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ssbr_pkg::ST_IDLE;
      pos_r          <= '0;
      flash_period_r <= ssbr_pkg::PERIOD_RST;
      countdown_r    <= '0;
      dot_r          <= '0;
      dot_blink_r    <= '0;
      digit_blink_r  <= '0;
      for (int g = 0; g < ssbr_pkg::GROUP_BLINK_DIGITS; g++) group_r[g] <= '0;
      shown_r        <= 1'b0;
      update_r       <= 1'b0;
      flash_r        <= 1'b0;
      flash_blank_r  <= 1'b0;
      seg_vld_r      <= '0;
      hold_vld_r     <= '0;
      obuf_vld_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      pos_r          <= pos_nxt;
      flash_period_r <= flash_period_nxt;
      countdown_r    <= countdown_nxt;
      dot_r          <= dot_nxt;
      dot_blink_r    <= dot_blink_nxt;
      digit_blink_r  <= digit_blink_nxt;
      group_r        <= group_nxt;
      shown_r        <= shown_nxt;
      update_r       <= update_nxt;
      flash_r        <= flash_nxt;
      flash_blank_r  <= flash_blank_nxt;
      seg_vld_r      <= seg_vld_nxt;
      hold_vld_r     <= hold_vld_nxt;
      obuf_vld_r     <= obuf_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_digit_r <= out_digit_nxt;
    out_seg_r   <= out_seg_nxt;
    out_on_r    <= out_on_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ----- tb/tb_seven_segment_blink_refresh.sv -----
`timescale 1ns / 1ps
// Testbench for seven_segment_blink_refresh. It runs a directed command table and then
// random commands, and checks every segment transfer against a behavioural display model.
// Uses ssbr_pkg, ssbr_in_if, ssbr_out_if and the RTL top level.
module tb_seven_segment_blink_refresh;

  localparam logic [3:0] OP_SPARE_LO    = 4'd9;
  localparam logic [3:0] OP_SPARE_HI    = 4'd15;
  localparam int         CLK_HALF       = 5;
  localparam int         CYCLE_LIMIT    = 500000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         SQUEEZE_CYCLES = 300;
  localparam int         DIR_ROWS       = 26;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] idx;
    logic [7:0] val;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] idx;
    logic [7:0] val;
    logic       typed;
    logic [7:0] t_seg;
    logic       t_on;
  } dir_row_t;

  typedef struct packed {
    logic [2:0] digit;
    logic [7:0] segments;
    logic       display_on;
    logic       last;
  } seg_xfer_t;

  // typed rows expect every digit to carry t_seg with phase t_on
  localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b1, 8'h00, 1'b1},
    '{ssbr_pkg::OP_FLASH_NOW,   3'd0, 8'h01, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b1, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DIGIT_SEGS,  3'd0, 8'hff, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DIGIT_SEGS,  3'd7, 8'h80, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DIGIT_SEGS,  3'd3, 8'h7f, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_GROUP_BLINK, 3'd0, 8'hff, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_GROUP_BLINK, 3'd1, 8'h55, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_GROUP_BLINK, 3'd7, 8'haa, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DOTS,        3'd0, 8'h81, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DOT_BLINK,   3'd0, 8'h0f, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_DIGIT_BLINK, 3'd0, 8'hf0, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_UPDATE_NOW,  3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_FLASH_NOW,   3'd0, 8'h01, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_HOLD_MASK,   3'd0, 8'hff, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_HOLD_MASK,   3'd7, 8'h0f, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_FLASH_NOW,   3'd0, 8'h01, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_FLASH_NOW,   3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_SPARE_LO,              3'd5, 8'h3c, 1'b0, 8'h00, 1'b0},
    '{OP_SPARE_HI,              3'd2, 8'hc3, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_UPDATE_NOW,  3'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{ssbr_pkg::OP_TICK,        3'd0, 8'h00, 1'b0, 8'h00, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  ssbr_in_if  in_chan ();
  ssbr_out_if out_chan ();

  seven_segment_blink_refresh u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // display model state
  logic [7:0] m_period;
  logic [7:0] m_seg_pattern [ssbr_pkg::DIGITS];
  logic [7:0] m_group_mask [ssbr_pkg::GROUP_BLINK_DIGITS];
  logic [7:0] m_hold [ssbr_pkg::DIGITS];
  logic [7:0] m_out_buf [ssbr_pkg::DIGITS];
  logic [7:0] m_dot_mask;
  logic [7:0] m_dot_blink;
  logic [7:0] m_digit_blink;
  logic [7:0] m_countdown;
  logic       m_shown;
  logic       m_update_req;
  logic       m_flash_req;
  logic       m_flash_blank;

  seg_xfer_t  refresh_run [ssbr_pkg::DIGITS];
  seg_xfer_t  seg_expect_q [$];
  seg_xfer_t  head_xfer;

  int         send_idle;
  int         recv_idle;
  logic       hold_out;
  logic       squeeze_go;
  int         err_count = 0;
  int         cycle_count = 0;
  int         n_cmds;
  int         n_xfers = 0;
  int         n_runs;

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transfers outstanding", cycle_count,
               seg_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: check each transfer, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      n_xfers++;
      if (seg_expect_q.size() == 0) begin
        $error("unexpected transfer: digit %0d segments %02h", out_chan.digit,
               out_chan.segments);
        err_count++;
      end else begin
        head_xfer = seg_expect_q.pop_front();
        if (out_chan.digit !== head_xfer.digit) begin
          $error("digit: expected %0d, got %0d", head_xfer.digit, out_chan.digit);
          err_count++;
        end
        if (out_chan.segments !== head_xfer.segments) begin
          $error("segments: expected %02h, got %02h", head_xfer.segments, out_chan.segments);
          err_count++;
        end
        if (out_chan.display_on !== head_xfer.display_on) begin
          $error("display_on: expected %0d, got %0d", head_xfer.display_on,
                 out_chan.display_on);
          err_count++;
        end
        if (out_chan.last !== head_xfer.last) begin
          $error("last: expected %0d, got %0d", head_xfer.last, out_chan.last);
          err_count++;
        end
      end
    end
    out_chan.ready <= !hold_out && ($urandom_range(99) >= recv_idle);
  end

  // long hold-off on the result side, counted here
  initial begin
    hold_out = 1'b0;
    wait (squeeze_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  function automatic int model_refresh();
    logic       shown;
    logic [7:0] enable;
    logic [7:0] dots;
    logic [7:0] data;
    shown         = m_flash_req ? !m_flash_blank : !m_shown;
    m_update_req  = 1'b0;
    m_flash_req   = 1'b0;
    m_flash_blank = 1'b0;
    m_countdown   = m_period;
    m_shown       = shown;
    enable        = shown ? 8'hff : ~m_digit_blink;
    dots          = shown ? (m_dot_mask | m_dot_blink) : (m_dot_mask & ~m_dot_blink);
    for (int p = 0; p < ssbr_pkg::DIGITS; p++) begin
      data = 8'h00;
      if (enable[p]) begin
        data                    = m_seg_pattern[p];
        data[ssbr_pkg::DOT_BIT] = 1'b0;
        if (p >= ssbr_pkg::GROUP_FIRST) begin
          if (shown) data = data | m_group_mask[p - ssbr_pkg::GROUP_FIRST];
          else data = data & ~m_group_mask[p - ssbr_pkg::GROUP_FIRST];
        end
      end
      if (dots[p]) data[ssbr_pkg::DOT_BIT] = 1'b1;
      data         = (data & ~m_hold[p]) | (m_out_buf[p] & m_hold[p]);
      m_out_buf[p] = data;
      refresh_run[p] = '{p[ssbr_pkg::DIGIT_W-1:0], data, shown, p == ssbr_pkg::DIGITS - 1};
    end
    return ssbr_pkg::DIGITS;
  endfunction

  // applies one command to the model; returns the number of transfers in refresh_run
  function automatic int model_command(input cmd_t c);
    case (c.op)
      ssbr_pkg::OP_TICK: begin
        if (m_flash_req || m_update_req || m_countdown == 8'd0) return model_refresh();
        m_countdown = m_countdown - 8'd1;
      end
      ssbr_pkg::OP_DIGIT_SEGS:  m_seg_pattern[c.idx] = c.val;
      ssbr_pkg::OP_GROUP_BLINK: begin
        if (c.idx < ssbr_pkg::GROUP_BLINK_DIGITS) m_group_mask[c.idx] = c.val;
      end
      ssbr_pkg::OP_HOLD_MASK:   m_hold[c.idx] = c.val;
      ssbr_pkg::OP_DOTS:        m_dot_mask = c.val;
      ssbr_pkg::OP_DOT_BLINK:   m_dot_blink = c.val;
      ssbr_pkg::OP_DIGIT_BLINK: m_digit_blink = c.val;
      ssbr_pkg::OP_UPDATE_NOW:  m_update_req = 1'b1;
      ssbr_pkg::OP_FLASH_NOW: begin
        m_flash_req   = 1'b1;
        m_flash_blank = c.val[0];
      end
      default: ;
    endcase
    return 0;
  endfunction

  function automatic logic cmd_ignored(input cmd_t c);
    return (c.op >= OP_SPARE_LO) ||
           (c.op == ssbr_pkg::OP_GROUP_BLINK && c.idx >= ssbr_pkg::GROUP_BLINK_DIGITS);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick  = $urandom_range(99);
    c.idx = 3'($urandom_range(ssbr_pkg::DIGITS - 1));
    c.val = 8'($urandom_range(255));
    if (pick < 38) c.op = ssbr_pkg::OP_TICK;
    else if (pick < 56) c.op = ssbr_pkg::OP_DIGIT_SEGS;
    else if (pick < 62) begin
      c.op = ssbr_pkg::OP_GROUP_BLINK;
      if ($urandom_range(3) != 0) c.idx = 3'($urandom_range(ssbr_pkg::GROUP_BLINK_DIGITS - 1));
    end else if (pick < 70) begin
      c.op = ssbr_pkg::OP_HOLD_MASK;
      if ($urandom_range(1) != 0) c.val = 8'h00;
    end else if (pick < 74) c.op = ssbr_pkg::OP_DOTS;
    else if (pick < 78) c.op = ssbr_pkg::OP_DOT_BLINK;
    else if (pick < 82) c.op = ssbr_pkg::OP_DIGIT_BLINK;
    else if (pick < 89) c.op = ssbr_pkg::OP_UPDATE_NOW;
    else if (pick < 95) c.op = ssbr_pkg::OP_FLASH_NOW;
    else c.op = 4'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return c;
  endfunction

  // valid stays high into the next command unless a gap is drawn
  task automatic send_cmd(input cmd_t c, input logic typed, input logic [7:0] t_seg,
                          input logic t_on);
    int n;
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= c.op;
    in_chan.index     <= c.idx;
    in_chan.value     <= c.val;
    do @(posedge clk); while (!in_chan.ready);
    n_cmds++;
    n = model_command(c);
    if (n != 0) n_runs++;
    for (int k = 0; k < n; k++) begin
      if (typed) begin
        seg_expect_q.push_back('{k[ssbr_pkg::DIGIT_W-1:0], t_seg, t_on,
                                 k == ssbr_pkg::DIGITS - 1});
      end else begin
        seg_expect_q.push_back(refresh_run[k]);
      end
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (seg_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [7:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    m_period = v;
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int target);
    cmd_t c;
    int   useful;
    useful = 0;
    while (useful < target) begin
      c = random_cmd();
      if (!cmd_ignored(c)) useful++;
      send_cmd(c, 1'b0, 8'h00, 1'b0);
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 8'h00;
    in_chan.valid     = 1'b0;
    in_chan.operation = ssbr_pkg::OP_TICK;
    in_chan.index     = 3'd0;
    in_chan.value     = 8'h00;
    squeeze_go        = 1'b0;
    n_cmds            = 0;
    n_runs            = 0;
    send_idle         = 27;
    recv_idle         = 63;

    m_period      = ssbr_pkg::PERIOD_RST;
    m_dot_mask    = 8'h00;
    m_dot_blink   = 8'h00;
    m_digit_blink = 8'h00;
    m_countdown   = 8'h00;
    m_shown       = 1'b0;
    m_update_req  = 1'b0;
    m_flash_req   = 1'b0;
    m_flash_blank = 1'b0;
    for (int d = 0; d < ssbr_pkg::DIGITS; d++) begin
      m_seg_pattern[d] = 8'h00;
      m_hold[d]        = 8'h00;
      m_out_buf[d]     = 8'h00;
    end
    for (int g = 0; g < ssbr_pkg::GROUP_BLINK_DIGITS; g++) m_group_mask[g] = 8'h00;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_cmd('{DIR_TAB[r].op, DIR_TAB[r].idx, DIR_TAB[r].val}, DIR_TAB[r].typed,
               DIR_TAB[r].t_seg, DIR_TAB[r].t_on);
    end

    write_period(8'd0);
    random_phase(125);

    send_idle = 63;
    recv_idle = 27;
    write_period(8'd255);
    random_phase(125);

    send_idle = 0;
    recv_idle = 0;
    write_period(8'd3);
    squeeze_go = 1'b1;
    send_cmd('{ssbr_pkg::OP_UPDATE_NOW, 3'd0, 8'h00}, 1'b0, 8'h00, 1'b0);
    send_cmd('{ssbr_pkg::OP_TICK, 3'd0, 8'h00}, 1'b0, 8'h00, 1'b0);
    random_phase(130);

    settle();
    $display("covered %0d commands over four countdown periods; %0d refresh runs gave %0d",
             n_cmds, n_runs, n_xfers);
    $display("segment transfers, with a long result hold-off stalling the command side");
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
